// ===== sv/pgm_pkg.sv =====
package pgm_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_NUM_LEVELS = 4;
    localparam int DEF_PIXEL_BITS = 16;

    // Fixed field widths on the ports.
    localparam int PIXEL_W     = 16;
    localparam int GRAD_W      = 24;
    localparam int SQ_W        = 47;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int LEVEL_W     = 2;

    // Highest level the level register can name, and the fraction bits of a level pixel.
    localparam int LEVEL_MAX = (1 << LEVEL_W) - 1;
    localparam int FRAC_BITS = 2 * LEVEL_MAX;
    localparam int MASK_W    = LEVEL_MAX;
    localparam int SHIFT_W   = $clog2(FRAC_BITS + 1);

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(640);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(480);
    localparam logic [LEVEL_W-1:0]    LEVEL_RESET  = '0;

    // Result buffer depth; it must cover every word that can be in flight.
    localparam int OUT_DEPTH = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_PYRAMID_LEVEL = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic [SQ_W-1:0]          grad_sq;
        logic                     last_of_frame;
    } grad_word_t;

endpackage

// ===== sv/pgm_if.sv =====
interface pgm_pixel_if import pgm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface pgm_grad_if import pgm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic [SQ_W-1:0]          grad_sq;
    logic                     last_of_frame;

    modport source (output valid, output grad_x, output grad_y, output grad_sq,
                    output last_of_frame, input ready);
    modport sink (input valid, input grad_x, input grad_y, input grad_sq,
                  input last_of_frame, output ready);
endinterface

// ===== sv/pyramid_gradient_magnitude.sv =====
// Pyramid gradient magnitude. Full-resolution pixels arrive in raster order on pixels; each
// 2^L x 2^L block is summed into a level pixel with 6 fraction bits, and for every interior
// level row the block returns the central differences grad_x and grad_y (6 fraction bits,
// horizontal neighbors taken along the linear raster so they wrap across row ends) and
// grad_sq with 12 fraction bits. The block takes one pixel per clock sustained while ready on
// pixels is high: the partial block sums live in a line memory that is read in stage 0 and
// written back from stage 1 with a forwarding path, and the last two level rows live in a
// second memory with one write and two read ports. An eight-word result buffer sits in front
// of gradients; ready on pixels drops only when that buffer together with the words still in
// the pipeline could fill it. The line memories need no clearing pass after reset. Any write
// to a defined register restarts the frame at row 0, column 0; the user must write registers
// only while the block is idle, and the block itself does not enforce this.
module pyramid_gradient_magnitude import pgm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int NUM_LEVELS = DEF_NUM_LEVELS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    pgm_pixel_if.sink               pixels,
    pgm_grad_if.source              gradients,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int RW       = $clog2(MAX_HEIGHT);
    localparam int WW       = $clog2(MAX_WIDTH + 1);
    localparam int HW       = $clog2(MAX_HEIGHT + 1);
    localparam int SW       = PIXEL_BITS + FRAC_BITS;
    localparam int DW       = SW + 1;
    localparam int LR_AW    = CW + 1;
    localparam int LR_DEPTH = 2 * (1 << CW);
    localparam int CNT_W    = $clog2(OUT_DEPTH + 1);
    localparam int CR_W     = CNT_W + 1;

    // Configuration and position.
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [LEVEL_W-1:0]    level_reg;
    logic [CW-1:0]         col_reg;
    logic [RW-1:0]         row_reg;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_next;

    logic [WW-1:0]      width_c;
    logic [HW-1:0]      height_c;
    logic [LEVEL_W-1:0] lv;
    logic [WW-1:0]      wl;
    logic [HW-1:0]      hl;
    logic [MASK_W-1:0]  mask;
    logic [MASK_W-1:0]  col_low;
    logic [MASK_W-1:0]  row_low;
    logic [CW-1:0]      x;
    logic [RW-1:0]      y;
    logic               in_acc;
    logic               in_frame;
    logic               blk_first;
    logic               blk_done;
    logic [LR_AW-1:0]   up_addr;
    logic [LR_AW-1:0]   right_addr;
    logic               cfg_restart;

    // Line memories and their registered read data.
    logic [SW-1:0] bsl_mem [MAX_WIDTH];
    logic [SW-1:0] lvl_mem [LR_DEPTH];
    logic [SW-1:0] bsl_rd_reg;
    logic [SW-1:0] up_rd_reg;
    logic [SW-1:0] right_rd_reg;

    // Stage 1: block sum update and level pixel.
    logic                  s1_valid_reg;
    logic [CW-1:0]         s1_x_reg;
    logic                  s1_par_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic                  s1_first_reg;
    logic                  s1_done_reg;
    logic                  s1_bfwd_reg;
    logic                  s1_rfwd_reg;
    logic                  s1_emit_reg;
    logic                  s1_last_reg;
    logic [SW-1:0]         sum_fwd_reg;
    logic [SW-1:0]         cur_fwd_reg;
    logic [SW-1:0]         sum_base;
    logic [SW-1:0]         sum;
    logic [SW-1:0]         cur;
    logic [SW-1:0]         right_val;
    logic [SHIFT_W-1:0]    shamt;

    // Stage 2: differences.
    logic          s2_lvl_reg;
    logic          s2_emit_reg;
    logic          s2_last_reg;
    logic [SW-1:0] s2_cur_reg;
    logic [SW-1:0] s2_up_reg;
    logic [SW-1:0] s2_right_reg;
    logic [SW-1:0] recent_reg [2];
    logic signed [DW-1:0] gx;
    logic signed [DW-1:0] gy;

    // Stage 3: squares.
    logic                 s3_emit_reg;
    logic                 s3_last_reg;
    logic signed [DW-1:0] s3_gx_reg;
    logic signed [DW-1:0] s3_gy_reg;
    logic signed [2*DW-1:0] gx_sq;
    logic signed [2*DW-1:0] gy_sq;

    // Stage 4: sum of squares.
    logic                 s4_emit_reg;
    logic                 s4_last_reg;
    logic signed [DW-1:0] s4_gx_reg;
    logic signed [DW-1:0] s4_gy_reg;
    logic [2*SW-1:0]      s4_gx2_reg;
    logic [2*SW-1:0]      s4_gy2_reg;
    logic [2*SW:0]        sq_sum;

    grad_word_t       push_word;
    grad_word_t       head_word;
    logic             fifo_valid;
    logic [CNT_W-1:0] fifo_count;
    logic [2:0]       inflight;
    logic             out_pop;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign cfg_restart = cfg_write &&
        (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_PYRAMID_LEVEL});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            level_reg  <= LEVEL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                REG_PYRAMID_LEVEL: level_reg  <= cfg_data[LEVEL_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(width_reg) < 32'd2)
            width_c = WW'(2);
        else if (32'(width_reg) > 32'(MAX_WIDTH))
            width_c = WW'(MAX_WIDTH);
        else
            width_c = WW'(width_reg);

        if (32'(height_reg) < 32'd2)
            height_c = HW'(2);
        else if (32'(height_reg) > 32'(MAX_HEIGHT))
            height_c = HW'(MAX_HEIGHT);
        else
            height_c = HW'(height_reg);

        if (32'(level_reg) > 32'(NUM_LEVELS - 1))
            lv = LEVEL_W'(NUM_LEVELS - 1);
        else
            lv = level_reg;
    end

    assign wl      = width_c >> lv;
    assign hl      = height_c >> lv;
    assign mask    = MASK_W'((32'd1 << lv) - 32'd1);
    assign col_low = MASK_W'(col_reg) & mask;
    assign row_low = MASK_W'(row_reg) & mask;
    assign x       = col_reg >> lv;
    assign y       = row_reg >> lv;

    assign in_frame  = (WW'(x) < wl) && (HW'(y) < hl);
    assign blk_first = (col_low == '0) && (row_low == '0);
    assign blk_done  = (col_low == mask) && (row_low == mask);

    // ------------------------------------------------------------------
    // Position counters
    // ------------------------------------------------------------------
    assign pixels.ready = rst_n && ((CR_W'(fifo_count) + CR_W'(inflight)) < CR_W'(OUT_DEPTH));
    assign in_acc       = pixels.valid && pixels.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (WW'(col_reg) + WW'(1) >= width_c)
            begin
                col_next = '0;
                row_next = (HW'(row_reg) + HW'(1) >= height_c) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: memory reads
    // ------------------------------------------------------------------
    // The right neighbor of the center one level row up is the next pixel along the raster,
    // which is the first pixel of the current row when the center sits at the row end.
    assign up_addr = {y[0], x};

    always_comb
    begin
        if (WW'(x) + WW'(1) < wl)
            right_addr = {~y[0], x + CW'(1)};
        else
            right_addr = {y[0], CW'(0)};
    end

    always_ff @(posedge clk)
    begin
        bsl_rd_reg   <= bsl_mem[x];
        up_rd_reg    <= lvl_mem[up_addr];
        right_rd_reg <= lvl_mem[right_addr];
        if (s1_valid_reg)
        begin
            bsl_mem[s1_x_reg] <= sum;
        end
        if (s1_valid_reg && s1_done_reg)
        begin
            lvl_mem[{s1_par_reg, s1_x_reg}] <= cur;
        end
        sum_fwd_reg <= sum;
        cur_fwd_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc && in_frame;
        end
    end

    // The word in stage 1 is written back at the same edge the new reads are taken, so a
    // read of the entry it writes picks the written value from the forwarding registers.
    always_ff @(posedge clk)
    begin
        s1_x_reg     <= x;
        s1_par_reg   <= y[0];
        s1_pix_reg   <= pixels.pixel[PIXEL_BITS-1:0];
        s1_first_reg <= blk_first;
        s1_done_reg  <= blk_done;
        s1_bfwd_reg  <= s1_valid_reg && (s1_x_reg == x);
        s1_rfwd_reg  <= s1_valid_reg && s1_done_reg && ({s1_par_reg, s1_x_reg} == right_addr);
        s1_emit_reg  <= (y >= RW'(2));
        s1_last_reg  <= (HW'(y) == hl - HW'(1)) && (WW'(x) == wl - WW'(1));
    end

    // ------------------------------------------------------------------
    // Stage 1: block sum and level pixel
    // ------------------------------------------------------------------
    assign sum_base = s1_bfwd_reg ? sum_fwd_reg : bsl_rd_reg;
    assign sum      = s1_first_reg ? SW'(s1_pix_reg) : sum_base + SW'(s1_pix_reg);
    assign shamt    = SHIFT_W'(FRAC_BITS) - SHIFT_W'({lv, 1'b0});
    assign cur      = sum << shamt;

    always_comb
    begin
        if (wl == WW'(1))
            right_val = cur;
        else if (s1_rfwd_reg)
            right_val = cur_fwd_reg;
        else
            right_val = right_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_lvl_reg  <= 1'b0;
            s2_emit_reg <= 1'b0;
        end
        else
        begin
            s2_lvl_reg  <= s1_valid_reg && s1_done_reg;
            s2_emit_reg <= s1_valid_reg && s1_done_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg  <= s1_last_reg;
        s2_cur_reg   <= cur;
        s2_up_reg    <= up_rd_reg;
        s2_right_reg <= right_val;
    end

    // ------------------------------------------------------------------
    // Stage 2: differences
    // ------------------------------------------------------------------
    // The left neighbor is the right neighbor read two level pixels earlier.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg[0] <= '0;
            recent_reg[1] <= '0;
        end
        else if (s2_lvl_reg)
        begin
            recent_reg[0] <= s2_right_reg;
            recent_reg[1] <= recent_reg[0];
        end
    end

    assign gx = $signed({1'b0, s2_right_reg}) - $signed({1'b0, recent_reg[1]});
    assign gy = $signed({1'b0, s2_cur_reg}) - $signed({1'b0, s2_up_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_emit_reg <= 1'b0;
        end
        else
        begin
            s3_emit_reg <= s2_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_last_reg <= s2_last_reg;
        s3_gx_reg   <= gx;
        s3_gy_reg   <= gy;
    end

    // ------------------------------------------------------------------
    // Stage 3: squares
    // ------------------------------------------------------------------
    assign gx_sq = s3_gx_reg * s3_gx_reg;
    assign gy_sq = s3_gy_reg * s3_gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_emit_reg <= 1'b0;
        end
        else
        begin
            s4_emit_reg <= s3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_last_reg <= s3_last_reg;
        s4_gx_reg   <= s3_gx_reg;
        s4_gy_reg   <= s3_gy_reg;
        s4_gx2_reg  <= gx_sq[2*SW-1:0];
        s4_gy2_reg  <= gy_sq[2*SW-1:0];
    end

    // ------------------------------------------------------------------
    // Stage 4: magnitude and result buffer
    // ------------------------------------------------------------------
    assign sq_sum = {1'b0, s4_gx2_reg} + {1'b0, s4_gy2_reg};

    always_comb
    begin
        push_word.grad_x        = GRAD_W'(s4_gx_reg);
        push_word.grad_y        = GRAD_W'(s4_gy_reg);
        push_word.grad_sq       = SQ_W'(sq_sum);
        push_word.last_of_frame = s4_last_reg;
    end

    assign inflight = 3'(s1_valid_reg) + 3'(s2_emit_reg) + 3'(s3_emit_reg) + 3'(s4_emit_reg);
    assign out_pop  = fifo_valid && gradients.ready;

    pgm_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s4_emit_reg),
        .push_word (push_word),
        .pop       (out_pop),
        .head_word (head_word),
        .not_empty (fifo_valid),
        .count     (fifo_count)
    );

    assign gradients.valid         = fifo_valid;
    assign gradients.grad_x        = head_word.grad_x;
    assign gradients.grad_y        = head_word.grad_y;
    assign gradients.grad_sq       = head_word.grad_sq;
    assign gradients.last_of_frame = head_word.last_of_frame;

endmodule

// ===== sv/pgm_out_fifo.sv =====
module pgm_out_fifo import pgm_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  grad_word_t                   push_word,
    input  logic                         pop,
    output grad_word_t                   head_word,
    output logic                         not_empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    grad_word_t      slots [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word = slots[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

// ===== sv/pgm_checker.sv =====
module pgm_checker import pgm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [GRAD_W-1:0] grad_x,
    input logic signed [GRAD_W-1:0] grad_y,
    input logic [SQ_W-1:0]          grad_sq,
    input logic                     last_of_frame
);

    // A word waiting on the output stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn before it was taken");

    // A stalled word keeps its contents.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(grad_x) && $stable(grad_y) &&
            $stable(grad_sq) && $stable(last_of_frame))
        else $error("output word changed while stalled");

    // Reset empties the result buffer.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // An empty output only fills with the word of an earlier accepted input pixel.
    a_rise_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 5))
        else $error("output word appeared without a matching input pixel");

endmodule

bind pyramid_gradient_magnitude pgm_checker u_pgm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixels.valid),
    .in_ready      (pixels.ready),
    .out_valid     (gradients.valid),
    .out_ready     (gradients.ready),
    .grad_x        (gradients.grad_x),
    .grad_y        (gradients.grad_y),
    .grad_sq       (gradients.grad_sq),
    .last_of_frame (gradients.last_of_frame)
);
